@@ rtl/dws_pkg.sv @@
// Shared types and constants for the deque with search.
`default_nettype none

package dws_pkg;

	localparam int DEPTH  = 16;
	localparam int DATA_W = 32;
	localparam int IDX_W  = $clog2(DEPTH);
	localparam int CNT_W  = IDX_W + 1;
	localparam int REQ_W  = 3;

	// request codes as seen on the input channel
	localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd0;
	localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd1;
	localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd2;
	localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd3;
	localparam logic [REQ_W-1:0] REQ_SEARCH     = 3'd4;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2,
		ST_MISS  = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		OP_NOP,
		OP_PUSH_FRONT,
		OP_PUSH_BACK,
		OP_POP_FRONT,
		OP_POP_BACK,
		OP_SEARCH
	} op_t;

	typedef struct packed {
		logic [REQ_W-1:0]         req_type;
		logic signed [DATA_W-1:0] value;
		logic [IDX_W-1:0]         search_start;
	} req_t;

	typedef struct packed {
		status_t                  status;
		logic signed [DATA_W-1:0] data;
		logic [IDX_W-1:0]         position;
		logic [CNT_W-1:0]         count;
	} rsp_t;

	// decoded command passed from the front end to the execution side
	typedef struct packed {
		op_t                      op;
		logic [DATA_W-1:0]        value;
		logic [IDX_W-1:0]         start;
	} cmd_t;

endpackage

`default_nettype wire

@@ rtl/deque_with_search.sv @@
// Top level of the bounded double-ended queue with search.
//
//   channel  dir  handshake             payload
//   req      in   req_valid/req_stall   req_type, value, search_start
//   rsp      out  rsp_valid/rsp_stall   status, data, position, count
//
// Push, empty pop, full push, unused codes: the result beat is registered straight from the command.
// Pop: the registered read port of the entry store, then the result register.
// Search: compares up to 16 entries, one compare per cycle through the single
//   read port; a miss at the start is answered without a read.
// The command queue holds each decoded request in a register and lets requests
//   keep coming while a search runs or a result is stalled, until it is full.
// Reset clears head, count and handshake state at once; the store needs no
//   clearing pass since only written entries are read.
`default_nettype none

module deque_with_search #(
	parameter int QUEUE_DEPTH = 2
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire dws_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	output dws_pkg::rsp_t      rsp
);

	dws_pkg::cmd_t cmd;
	logic          cmd_valid;
	logic          cmd_take;

	// decode request beats and hold them until the execution side is free
	dws_front #(
		.QDEPTH(QUEUE_DEPTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.cmd_valid(cmd_valid),
		.cmd_take (cmd_take),
		.cmd      (cmd)
	);

	// carry out one command at a time and register its result beat
	dws_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd      (cmd),
		.cmd_take (cmd_take),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

endmodule

`default_nettype wire

@@ rtl/dws_front.sv @@
// Front end: accepts request beats, decodes them and queues the commands.
`default_nettype none

module dws_front #(
	parameter int QDEPTH = 2
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_stall,
	input  wire dws_pkg::req_t  req,
	output logic                cmd_valid,
	input  wire logic           cmd_take,
	output dws_pkg::cmd_t       cmd
);

	localparam int PTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int FILL_W = $clog2(QDEPTH + 1);

	dws_pkg::cmd_t     q_mem [QDEPTH];
	dws_pkg::cmd_t     dec;
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [FILL_W-1:0] fill_q;
	logic              push, pop;

	always_comb begin
		dec.value = req.value;
		dec.start = req.search_start;
		unique case (req.req_type)
			dws_pkg::REQ_PUSH_FRONT: dec.op = dws_pkg::OP_PUSH_FRONT;
			dws_pkg::REQ_PUSH_BACK:  dec.op = dws_pkg::OP_PUSH_BACK;
			dws_pkg::REQ_POP_FRONT:  dec.op = dws_pkg::OP_POP_FRONT;
			dws_pkg::REQ_POP_BACK:   dec.op = dws_pkg::OP_POP_BACK;
			dws_pkg::REQ_SEARCH:     dec.op = dws_pkg::OP_SEARCH;
			default:                 dec.op = dws_pkg::OP_NOP;
		endcase
	end

	assign req_stall = (fill_q == FILL_W'(QDEPTH));
	assign cmd_valid = (fill_q != '0);
	assign push      = req_valid && !req_stall;
	assign pop       = cmd_take && cmd_valid;
	assign cmd       = q_mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[wr_ptr_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			unique case ({push, pop})
				2'b10:   fill_q <= fill_q + FILL_W'(1);
				2'b01:   fill_q <= fill_q - FILL_W'(1);
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

`default_nettype wire

@@ rtl/dws_back.sv @@
// Execution side: ring storage, head and count, pop and search sequencing.
`default_nettype none

module dws_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           cmd_valid,
	input  wire dws_pkg::cmd_t  cmd,
	output logic                cmd_take,
	output logic                rsp_valid,
	input  wire logic           rsp_stall,
	output dws_pkg::rsp_t       rsp
);

	localparam int IDX_W  = dws_pkg::IDX_W;
	localparam int CNT_W  = dws_pkg::CNT_W;
	localparam int DATA_W = dws_pkg::DATA_W;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_POP  = 3'b010,
		S_SCAN = 3'b100
	} state_t;

	state_t            state_q, state_d;
	logic [DATA_W-1:0] mem [dws_pkg::DEPTH];
	logic [DATA_W-1:0] rd_data_q, key_q;
	logic [IDX_W-1:0]  head_q, head_d, k_q, k_d;
	logic [CNT_W-1:0]  count_q, count_d;
	logic [IDX_W-1:0]  rd_addr, wr_addr, cnt_idx;
	logic              rd_en, wr_en, load, res_free, full, empty;
	logic              rsp_valid_q;
	dws_pkg::rsp_t     rsp_q, rsp_d;

	assign res_free  = !rsp_valid_q || !rsp_stall;
	assign cmd_take  = (state_q == S_IDLE) && cmd_valid && res_free;
	assign full      = (count_q == CNT_W'(dws_pkg::DEPTH));
	assign empty     = (count_q == '0);
	// depth is a power of two, so ring offsets wrap by truncation
	assign cnt_idx   = count_q[IDX_W-1:0];
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_comb begin
		state_d = state_q;
		head_d  = head_q;
		count_d = count_q;
		k_d     = k_q;
		rd_en   = 1'b0;
		rd_addr = '0;
		wr_en   = 1'b0;
		wr_addr = '0;
		load    = 1'b0;
		rsp_d   = '{status: dws_pkg::ST_OK, data: '0, position: '0, count: count_q};
		unique case (state_q)
			S_IDLE: begin
				if (cmd_take) begin
					unique case (cmd.op)
						dws_pkg::OP_PUSH_FRONT,
						dws_pkg::OP_PUSH_BACK: begin
							load = 1'b1;
							if (full) begin
								rsp_d.status = dws_pkg::ST_FULL;
							end else begin
								wr_en   = 1'b1;
								count_d = count_q + CNT_W'(1);
								if (cmd.op == dws_pkg::OP_PUSH_FRONT) begin
									head_d  = head_q - IDX_W'(1);
									wr_addr = head_q - IDX_W'(1);
								end else begin
									wr_addr = head_q + cnt_idx;
								end
								rsp_d.count = count_d;
							end
						end
						dws_pkg::OP_POP_FRONT,
						dws_pkg::OP_POP_BACK: begin
							if (empty) begin
								load         = 1'b1;
								rsp_d.status = dws_pkg::ST_EMPTY;
								rsp_d.data   = '1;
							end else begin
								rd_en   = 1'b1;
								count_d = count_q - CNT_W'(1);
								state_d = S_POP;
								if (cmd.op == dws_pkg::OP_POP_FRONT) begin
									rd_addr = head_q;
									head_d  = head_q + IDX_W'(1);
								end else begin
									rd_addr = head_q + cnt_idx - IDX_W'(1);
								end
							end
						end
						dws_pkg::OP_SEARCH: begin
							if (CNT_W'(cmd.start) >= count_q) begin
								load         = 1'b1;
								rsp_d.status = dws_pkg::ST_MISS;
							end else begin
								rd_en   = 1'b1;
								rd_addr = head_q + cmd.start;
								k_d     = cmd.start;
								state_d = S_SCAN;
							end
						end
						default: begin
							load = 1'b1;
						end
					endcase
				end
			end
			S_POP: begin
				load       = 1'b1;
				rsp_d.data = rd_data_q;
				state_d    = S_IDLE;
			end
			S_SCAN: begin
				if (rd_data_q == key_q) begin
					load           = 1'b1;
					rsp_d.position = k_q;
					state_d        = S_IDLE;
				end else if (CNT_W'(k_q) + CNT_W'(1) >= count_q) begin
					load         = 1'b1;
					rsp_d.status = dws_pkg::ST_MISS;
					state_d      = S_IDLE;
				end else begin
					rd_en   = 1'b1;
					rd_addr = head_q + k_q + IDX_W'(1);
					k_d     = k_q + IDX_W'(1);
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= cmd.value;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
		if (cmd_take) begin
			key_q <= cmd.value;
		end
		if (load) begin
			rsp_q <= rsp_d;
		end
		k_q <= k_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			count_q <= count_d;
			if (load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/dws_checker.sv @@
// Port-level checks on the result channel, bound to the top level.
`default_nettype none

module dws_checker (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          rsp_valid,
	input wire logic          rsp_stall,
	input wire dws_pkg::rsp_t rsp
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("result beat changed while stalled");

	a_empty_pop: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == dws_pkg::ST_EMPTY |-> rsp.data == '1 && rsp.count == '0)
		else $error("empty status with wrong data or count");

	a_full_push: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == dws_pkg::ST_FULL
		|-> rsp.count == dws_pkg::CNT_W'(dws_pkg::DEPTH))
		else $error("full status while not full");

	a_position: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.position != '0 |-> rsp.status == dws_pkg::ST_OK)
		else $error("nonzero position without a match");

endmodule

bind deque_with_search dws_checker u_dws_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.rsp_valid(rsp_valid),
	.rsp_stall(rsp_stall),
	.rsp      (rsp)
);

`default_nettype wire

@@ sim/deque_with_search_tb.sv @@
// Self-checking testbench for the deque with search: directed and random requests.
`timescale 1ns / 1ps

module deque_with_search_tb;

	localparam int CLK_PERIOD   = 4;
	localparam int RESET_CYCLES = 5;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 48;
	localparam int RANDOM_ITEMS = 1250;

	// request codes the block leaves unused
	localparam logic [dws_pkg::REQ_W-1:0] REQ_SPARE_5 = 3'd5;
	localparam logic [dws_pkg::REQ_W-1:0] REQ_SPARE_6 = 3'd6;
	localparam logic [dws_pkg::REQ_W-1:0] REQ_SPARE_7 = 3'd7;

	localparam logic signed [dws_pkg::DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;
	localparam logic signed [dws_pkg::DATA_W-1:0] VAL_MIN = 32'sh8000_0000;

	// stimulus shapes for the random part
	typedef enum int {
		MODE_FILL,
		MODE_DRAIN,
		MODE_SEARCH,
		MODE_NOISE
	} burst_mode_t;

	// Mirror of the deque: tracks ring contents, head and fill level, and
	// queues the result each accepted request must produce.
	class deque_mirror;
		logic signed [dws_pkg::DATA_W-1:0] entries [dws_pkg::DEPTH];
		logic [dws_pkg::IDX_W-1:0]         head;
		logic [dws_pkg::CNT_W-1:0]         fill;
		dws_pkg::rsp_t                     awaited [$];
		int                                mismatches;
		int                                requests;
		int                                full_refusals;
		int                                empty_pops;
		int                                search_hits;
		int                                search_misses;

		function new();
			foreach (entries[i]) entries[i] = '0;
			head = '0;
			fill = '0;
			mismatches = 0;
			requests = 0;
			full_refusals = 0;
			empty_pops = 0;
			search_hits = 0;
			search_misses = 0;
		endfunction

		function logic signed [dws_pkg::DATA_W-1:0] entry_at(int offset);
			return entries[head + dws_pkg::IDX_W'(offset)];
		endfunction

		// Advance the mirror by one accepted request and queue its result.
		function void log_request(dws_pkg::req_t r);
			dws_pkg::rsp_t             res;
			logic [dws_pkg::IDX_W-1:0] idx;
			bit                        hit;
			res = '0;
			res.status = dws_pkg::ST_OK;
			hit = 1'b0;
			case (r.req_type)
				dws_pkg::REQ_PUSH_FRONT, dws_pkg::REQ_PUSH_BACK: begin
					if (fill >= dws_pkg::CNT_W'(dws_pkg::DEPTH)) begin
						res.status = dws_pkg::ST_FULL;
						full_refusals++;
					end else begin
						if (r.req_type == dws_pkg::REQ_PUSH_FRONT) begin
							head = head - 1'b1;
							idx = head;
						end else begin
							idx = head + fill[dws_pkg::IDX_W-1:0];
						end
						entries[idx] = r.value;
						fill++;
					end
				end
				dws_pkg::REQ_POP_FRONT, dws_pkg::REQ_POP_BACK: begin
					if (fill == '0) begin
						res.status = dws_pkg::ST_EMPTY;
						res.data = -1;
						empty_pops++;
					end else begin
						if (r.req_type == dws_pkg::REQ_POP_FRONT) begin
							res.data = entries[head];
							head = head + 1'b1;
						end else begin
							res.data = entries[head + dws_pkg::IDX_W'(fill - 1'b1)];
						end
						fill--;
					end
				end
				dws_pkg::REQ_SEARCH: begin
					res.status = dws_pkg::ST_MISS;
					for (int k = int'(r.search_start); k < int'(fill); k++) begin
						if (!hit && entries[head + dws_pkg::IDX_W'(k)] == r.value) begin
							hit = 1'b1;
							res.status = dws_pkg::ST_OK;
							res.position = dws_pkg::IDX_W'(k);
						end
					end
					if (hit) search_hits++;
					else search_misses++;
				end
				default: ;
			endcase
			res.count = fill;
			awaited.push_back(res);
			requests++;
		endfunction

		// Compare one delivered result with the oldest awaited one.
		function void match_result(dws_pkg::rsp_t got);
			dws_pkg::rsp_t want;
			if (awaited.size() == 0) begin
				$display({"%0t: unexpected result, expected none, ",
					"got status %0d data %0d pos %0d count %0d"},
					$time, got.status, got.data, got.position, got.count);
				mismatches++;
				return;
			end
			want = awaited.pop_front();
			if (got.status !== want.status) begin
				$display("%0t: status mismatch, expected %0d, got %0d",
					$time, want.status, got.status);
				mismatches++;
			end
			if (got.data !== want.data) begin
				$display("%0t: data mismatch, expected %0d, got %0d",
					$time, want.data, got.data);
				mismatches++;
			end
			if (got.position !== want.position) begin
				$display("%0t: position mismatch, expected %0d, got %0d",
					$time, want.position, got.position);
				mismatches++;
			end
			if (got.count !== want.count) begin
				$display("%0t: count mismatch, expected %0d, got %0d",
					$time, want.count, got.count);
				mismatches++;
			end
		endfunction
	endclass

	logic           clk       = 1'b0;
	logic           arst_n    = 1'b0;
	logic           req_valid = 1'b0;
	logic           rsp_stall = 1'b0;
	dws_pkg::req_t  req       = '0;
	logic           req_stall;
	logic           rsp_valid;
	dws_pkg::rsp_t  rsp;

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int cycle_count    = 0;

	deque_mirror mirror = new();

	deque_with_search uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Receiver: stall at random, updated away from the sampling edge.
	always @(negedge clk) begin
		rsp_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// Check every result beat taken at a rising edge.
	always @(posedge clk) begin
		if (arst_n === 1'b1 && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
			mirror.match_result(rsp);
		end
	end

	// Watchdog: end the run with an error once the cycle limit is reached.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("%0t: cycle limit %0d reached, %0d results outstanding",
			$time, CYCLE_LIMIT, mirror.awaited.size());
		$display("TB_ERROR");
		$finish;
	end

	// Present one request beat and hold it until the block takes it.
	// Entered and left just after a falling edge.
	task automatic send_beat(dws_pkg::req_t r);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid = 1'b0;
			@(negedge clk);
		end
		req = r;
		req_valid = 1'b1;
		do @(posedge clk); while (req_stall);
		mirror.log_request(r);
		@(negedge clk);
	endtask

	task automatic send_fields(logic [dws_pkg::REQ_W-1:0] code,
			logic signed [dws_pkg::DATA_W-1:0] v, logic [dws_pkg::IDX_W-1:0] start);
		dws_pkg::req_t r;
		r.req_type = code;
		r.value = v;
		r.search_start = start;
		send_beat(r);
	endtask

	// Drop valid and hold off until every awaited result has come back.
	task automatic hold_until_drained();
		req_valid = 1'b0;
		while (mirror.awaited.size() != 0) @(negedge clk);
	endtask

	// Favor small values so searches meet duplicates, plus the extremes.
	function automatic logic signed [dws_pkg::DATA_W-1:0] pick_value();
		int roll;
		roll = $urandom_range(99);
		if (roll < 25) return $urandom_range(3);
		if (roll < 35) begin
			case ($urandom_range(3))
				0: return VAL_MAX;
				1: return VAL_MIN;
				2: return '0;
				default: return -1;
			endcase
		end
		return $urandom;
	endfunction

	// Random bursts: fill and drain runs walk the deque between empty and
	// full, search runs look for present and absent values, noise mixes in
	// unused codes and arbitrary fields.
	task automatic run_random(int quota, bit pause_midway);
		dws_pkg::req_t               r;
		burst_mode_t                 mode;
		logic [dws_pkg::REQ_W-1:0]   push_any;
		logic [dws_pkg::REQ_W-1:0]   pop_any;
		int                          done;
		int                          burst_len;
		int                          roll;
		int                          depth_now;
		bit                          paused;
		done = 0;
		paused = 1'b0;
		while (done < quota) begin
			case ($urandom_range(99) / 25)
				0: mode = MODE_FILL;
				1: mode = MODE_DRAIN;
				2: mode = MODE_SEARCH;
				default: mode = ($urandom_range(2) == 0) ? MODE_NOISE : MODE_SEARCH;
			endcase
			burst_len = $urandom_range(30, 8);
			for (int j = 0; j < burst_len && done < quota; j++) begin
				depth_now = int'(mirror.fill);
				roll = $urandom_range(99);
				r.value = pick_value();
				r.search_start = dws_pkg::IDX_W'($urandom_range(dws_pkg::DEPTH - 1));
				push_any = $urandom_range(1) ? dws_pkg::REQ_PUSH_BACK :
					dws_pkg::REQ_PUSH_FRONT;
				pop_any = $urandom_range(1) ? dws_pkg::REQ_POP_BACK :
					dws_pkg::REQ_POP_FRONT;
				case (mode)
					MODE_FILL:
						r.req_type = (roll < 85) ? push_any :
							(roll < 92) ? dws_pkg::REQ_SEARCH : pop_any;
					MODE_DRAIN:
						r.req_type = (roll < 85) ? pop_any :
							(roll < 92) ? dws_pkg::REQ_SEARCH : push_any;
					MODE_SEARCH:
						r.req_type = (roll < 55) ? dws_pkg::REQ_SEARCH :
							(roll < 80) ? push_any : pop_any;
					default: begin
						r.req_type = dws_pkg::REQ_W'($urandom_range(7));
						r.value = $urandom;
					end
				endcase
				if (r.req_type == dws_pkg::REQ_SEARCH && mode != MODE_NOISE) begin
					// look mostly for something stored, mostly from a start no further than the fill level
					if ($urandom_range(99) < 65 && depth_now > 0)
						r.value = mirror.entry_at($urandom_range(depth_now - 1));
					roll = $urandom_range(99);
					if (roll < 40)
						r.search_start = '0;
					else if (roll < 80)
						r.search_start = (depth_now > dws_pkg::DEPTH - 1) ?
							dws_pkg::IDX_W'($urandom_range(dws_pkg::DEPTH - 1)) :
							dws_pkg::IDX_W'($urandom_range(depth_now));
				end
				send_beat(r);
				if (r.req_type <= dws_pkg::REQ_SEARCH) done++;
				if (pause_midway && !paused && done >= quota / 2) begin
					hold_until_drained();
					paused = 1'b1;
				end
			end
		end
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: empty deque, unused codes, extremes, search edges, pops.
		send_fields(dws_pkg::REQ_POP_FRONT, '0, '0);
		send_fields(dws_pkg::REQ_POP_BACK, VAL_MAX, 4'hf);
		send_fields(dws_pkg::REQ_SEARCH, '0, '0);
		send_fields(REQ_SPARE_5, VAL_MIN, 4'hf);
		send_fields(REQ_SPARE_6, -1, 4'h5);
		send_fields(REQ_SPARE_7, 32'sh5555_5555, 4'ha);
		send_fields(dws_pkg::REQ_PUSH_BACK, VAL_MAX, '0);
		send_fields(dws_pkg::REQ_PUSH_FRONT, VAL_MIN, '0);
		send_fields(dws_pkg::REQ_PUSH_BACK, -1, '0);
		send_fields(dws_pkg::REQ_PUSH_FRONT, '0, '0);
		send_fields(dws_pkg::REQ_SEARCH, -1, '0);
		send_fields(dws_pkg::REQ_SEARCH, '0, 4'h1);
		send_fields(dws_pkg::REQ_SEARCH, VAL_MAX, 4'hf);
		send_fields(dws_pkg::REQ_SEARCH, VAL_MIN, 4'h1);
		send_fields(dws_pkg::REQ_SEARCH, VAL_MAX, 4'h4);
		send_fields(dws_pkg::REQ_POP_FRONT, '0, '0);
		send_fields(dws_pkg::REQ_POP_BACK, '0, '0);
		send_fields(dws_pkg::REQ_POP_BACK, '0, '0);
		send_fields(dws_pkg::REQ_POP_FRONT, '0, '0);
		send_fields(dws_pkg::REQ_PUSH_FRONT, 32'sh5555_5555, '0);
		send_fields(dws_pkg::REQ_PUSH_BACK, 32'shaaaa_aaaa, '0);
		send_fields(dws_pkg::REQ_SEARCH, 32'shaaaa_aaaa, '0);
		send_fields(dws_pkg::REQ_SEARCH, 32'sh5555_5555, 4'h1);
		hold_until_drained();

		// sender sparse idling, receiver heavy stalls
		send_idle_pct = 11;
		recv_stall_pct = 47;
		run_random(RANDOM_ITEMS / 3, 1'b1);
		hold_until_drained();

		// swap the roles
		send_idle_pct = 47;
		recv_stall_pct = 11;
		run_random(RANDOM_ITEMS / 3, 1'b0);
		hold_until_drained();

		// full rate both ways
		send_idle_pct = 0;
		recv_stall_pct = 0;
		run_random(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3), 1'b0);

		req_valid = 1'b0;
		while (mirror.awaited.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("Ran %0d requests in %0d cycles: %0d full refusals, %0d empty pops,",
			mirror.requests, cycle_count, mirror.full_refusals, mirror.empty_pops);
		$display("%0d search hits, %0d search misses, %0d mismatches.",
			mirror.search_hits, mirror.search_misses, mirror.mismatches);
		if (mirror.mismatches == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
